// ===== sv/hqe_pkg.sv =====
// Package for the histogram quartile estimator: payload structs, constants,
// controller/datapath command and status types. No dependencies.
`timescale 1ns / 1ps
package hqe_pkg;
  localparam int BinBits   = 10;
  localparam int NumBins   = 1 << BinBits;
  localparam int CountBits = 32;
  localparam int CumBits   = 34;

  localparam logic [0:0] OP_ADD   = 1'b0;
  localparam logic [0:0] OP_QUERY = 1'b1;

  typedef struct packed {
    logic [0:0] opcode;
    logic [9:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic signed [19:0] mean_fx;
    logic        [17:0] stddev_fx;
    logic        [31:0] sample_total;
    logic               empty_flag;
  } out_item_t;

  // commands from the controller
  typedef struct packed {
    logic clr_wr;      // write zero at clear address
    logic rd;          // read bin at addr
    logic inc_wr;      // write incremented read data at addr
    logic walk_start;  // clear walk accumulators
    logic walk_step;   // consume read data as bin addr_d
    logic div_start;   // start quantile divisions
    logic sd_start;    // start stddev reciprocal multiply
    logic [BinBits-1:0] addr;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic done75;      // top quartile found
    logic empty;
  } sts_t;
endpackage

// ===== sv/hqe_divider.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Depends on hqe_pkg (import only).
`timescale 1ns / 1ps
module hqe_divider import hqe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        busy,
  output logic [63:0] quo
);
  logic [63:0] rem;
  logic [63:0] den_r;
  logic [6:0]  cnt;
  logic [64:0] trial;

  assign trial = {rem[63:0], quo[63]} - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      cnt   <= 7'd64;
      quo   <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      if (!trial[64]) begin
        rem <= trial[63:0];
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= {rem[62:0], quo[63]};
        quo <= {quo[62:0], 1'b0};
      end
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) busy <= 1'b0;
    end
  end
endmodule

// ===== sv/hqe_datapath.sv =====
// Datapath: bin memory, total counter, quantile walk and the division units.
// Depends on hqe_pkg and hqe_divider.
`timescale 1ns / 1ps
module hqe_datapath import hqe_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      cmd,
  output sts_t      sts,
  output out_item_t res
);
  // stddev = round(iqr / 1.3489796) = floor((iqr*2500000 + 1686224) / 3372449)
  localparam logic [31:0] SdRecip = 32'((64'd2500000 << 32) / 64'd3372449);
  localparam logic [31:0] SdBias  = 32'((64'd1686224 << 32) / 64'd3372449);
  localparam logic [21:0] SdDen   = 22'd3372449;

  logic [CountBits-1:0] mem [NumBins];
  logic [CountBits-1:0] rdata;
  logic [BinBits-1:0]   addr_d;
  logic [CountBits-1:0] total;
  logic [CumBits-1:0]   cum;
  logic [CumBits+1:0]   nc4, t1, t2, t3;
  logic                 s25, s50, s75;
  logic [BinBits-1:0]   b25, b50, b75;
  logic [CumBits-1:0]   w25, w50, w75;
  logic [CountBits-1:0] c25, c50, c75;
  logic [1:0]           dsel;
  logic                 div_start, div_busy, dv_go;
  logic [63:0]          dnum, dden, dquo;
  logic [CumBits+1:0]   numk;
  logic signed [23:0]   q25, q50, q75, iqr;
  logic [BinBits-1:0]   bsel;
  logic [CumBits-1:0]   wsel;
  logic [CountBits-1:0] csel;
  logic [1:0]           ksel;
  logic [18:0]          iqr_x;
  logic [1:0]           sd_stage;
  logic [50:0]          sd_prod;
  logic [39:0]          sd_num, sd_qd;
  logic [18:0]          sd_q, sd_val;

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) mem[cmd.addr] <= '0;
    else if (cmd.inc_wr && rdata != '1) mem[cmd.addr] <= rdata + 1'b1;
    if (cmd.rd) rdata <= mem[cmd.addr];
    addr_d <= cmd.addr;
  end

  assign nc4 = {cum + CumBits'(rdata), 2'b00};
  assign t1  = (CumBits+2)'(total);
  assign t2  = (CumBits+2)'({total, 1'b0});
  assign t3  = t1 + t2;

  always_ff @(posedge clk) begin
    if (rst) total <= '0;
    else if (cmd.inc_wr && total != '1) total <= total + 1'b1;
    if (cmd.walk_start) begin
      cum <= '0; s25 <= 1'b0; s50 <= 1'b0; s75 <= 1'b0;
    end else if (cmd.walk_step && rdata != '0 && !s75) begin
      if (!s25 && nc4 >= t1) begin s25 <= 1'b1; b25 <= addr_d; w25 <= cum; c25 <= rdata; end
      if (!s50 && nc4 >= t2) begin s50 <= 1'b1; b50 <= addr_d; w50 <= cum; c50 <= rdata; end
      if (nc4 >= t3) begin s75 <= 1'b1; b75 <= addr_d; w75 <= cum; c75 <= rdata; end
      cum <= cum + CumBits'(rdata);
    end
  end

  always_comb begin
    case (dsel)
      2'd0:    begin bsel = b25; wsel = w25; csel = c25; ksel = 2'd1; end
      2'd1:    begin bsel = b50; wsel = w50; csel = c50; ksel = 2'd2; end
      default: begin bsel = b75; wsel = w75; csel = c75; ksel = 2'd3; end
    endcase
    numk = (ksel == 2'd1) ? t1 : ((ksel == 2'd2) ? t2 : t3);
    numk = (numk > {wsel, 2'b00}) ? numk - {wsel, 2'b00} : '0;
    dnum = {22'd0, numk, 6'd0} + 64'(csel[CountBits-1:1]);
    dden = 64'(csel);
  end

  hqe_divider u_div (.clk(clk), .rst(rst), .start(div_start), .num(dnum), .den(dden),
    .busy(div_busy), .quo(dquo));

  // sequence the three quantile divisions
  always_ff @(posedge clk) begin
    if (rst) begin
      dsel <= 2'd0; dv_go <= 1'b0; div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (cmd.div_start) begin
        dsel <= 2'd0; dv_go <= 1'b1; div_start <= 1'b1;
      end else if (dv_go && !div_busy && !div_start) begin
        case (dsel)
          2'd0: q25 <= 24'(bsel) * 24'sd256 - 24'sd128 + 24'(dquo[15:0]);
          2'd1: q50 <= 24'(bsel) * 24'sd256 - 24'sd128 + 24'(dquo[15:0]);
          default: q75 <= 24'(bsel) * 24'sd256 - 24'sd128 + 24'(dquo[15:0]);
        endcase
        if (dsel == 2'd2) dv_go <= 1'b0;
        else begin dsel <= dsel + 2'd1; div_start <= 1'b1; end
      end
    end
  end

  assign iqr   = (q75 > q25) ? q75 - q25 : '0;
  assign iqr_x = iqr[18:0];

  // estimate the quotient by reciprocal multiply, then raise it by one if the
  // remainder still covers the divisor
  always_ff @(posedge clk) begin
    if (rst) sd_stage <= '0;
    else sd_stage <= {sd_stage[0], cmd.sd_start};
    if (cmd.sd_start) begin
      sd_prod <= 51'(iqr_x) * 51'(SdRecip) + 51'(SdBias);
      sd_num  <= 40'(iqr_x) * 40'd2500000 + 40'd1686224;
    end
    if (sd_stage[0]) begin
      sd_q  <= sd_prod[50:32];
      sd_qd <= 40'(sd_prod[50:32]) * 40'(SdDen);
    end
    if (sd_stage[1]) sd_val <= (sd_num - sd_qd >= 40'(SdDen)) ? sd_q + 19'd1 : sd_q;
  end

  assign sts.div_busy = div_busy || div_start || dv_go || (sd_stage != '0);
  assign sts.done75 = s75;
  assign sts.empty = (total == '0);

  always_comb begin
    res.empty_flag   = sts.empty;
    res.sample_total = total;
    res.mean_fx      = sts.empty ? '0 : q50[19:0];
    res.stddev_fx    = sts.empty ? '0 : ((sd_val > 19'd262143) ? 18'h3FFFF : sd_val[17:0]);
  end
endmodule

// ===== sv/hqe_ctrl.sv =====
// Controller FSM: clearing pass, sample read-modify-write, query walk and divide.
// Depends on hqe_pkg.
`timescale 1ns / 1ps
module hqe_ctrl import hqe_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output cmd_t      cmd,
  input  sts_t      sts
);
  localparam logic [2:0] S_CLR = 3'd0, S_IDLE = 3'd1, S_INC = 3'd2, S_WALK = 3'd3,
    S_DIV = 3'd4, S_SD = 3'd5, S_SDW = 3'd6, S_OUT = 3'd7;
  logic [2:0] state;
  logic [BinBits-1:0] addr;
  logic last, wait1;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd = '0;
    cmd.addr = addr;
    case (state)
      S_CLR:  cmd.clr_wr = 1'b1;
      S_IDLE: begin
        cmd.addr = (in_item.opcode == OP_ADD) ? in_item.sample_value : '0;
        cmd.rd = in_valid;
        cmd.walk_start = 1'b1;
      end
      S_INC:  cmd.inc_wr = 1'b1;
      S_WALK: begin cmd.rd = 1'b1; cmd.walk_step = wait1; end
      S_DIV:  cmd.div_start = 1'b1;
      S_SD:   cmd.sd_start = !sts.div_busy;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR; addr <= '0; last <= 1'b0; wait1 <= 1'b0;
    end else begin
      case (state)
        S_CLR: begin
          addr <= addr + 1'b1;
          if (addr == '1) state <= S_IDLE;
        end
        S_IDLE: if (in_valid) begin
          if (in_item.opcode == OP_ADD) begin
            state <= S_INC; addr <= cmd.addr;
          end else if (sts.empty) state <= S_OUT;
          else begin
            state <= S_WALK; addr <= 10'd1; wait1 <= 1'b1; last <= 1'b0;
          end
        end
        S_INC: state <= S_IDLE;
        S_WALK: begin
          // advance one bin a cycle until the top quartile is found or the last bin is read
          if (sts.done75 || last) state <= S_DIV;
          else begin
            if (addr == '1) last <= 1'b1;
            addr <= addr + 1'b1;
          end
        end
        S_DIV: state <= S_SD;
        S_SD: if (!sts.div_busy) state <= S_SDW;
        S_SDW: if (!sts.div_busy) state <= S_OUT;
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_clr_done: assert property (@(posedge clk) disable iff (rst)
    state == S_CLR && addr == '1 |=> state == S_IDLE) else $error("clear pass overrun");
`endif
endmodule

// ===== sv/histogram_quartile_estimator.sv =====
// Histogram quartile estimator: accepts samples and statistics queries.
// Sample (opcode 0): counted in its bin (saturating); no result.
// Query (opcode 1): walks bins from 0 upward one per cycle until the 0.75
// quantile bin is reached or the last bin is read, then three serial
// divisions for the quantiles, then a reciprocal multiply with a correction
// step for the stddev, then presents one result on the output channel.
// Empty store: the result, zero fields with empty_flag, is offered the cycle
// after the query is accepted.
// Channels are valid/ready; in_ready is low while an item is in work or a
// result waits. A stalled receiver holds the result steady and blocks input.
// Reset: synchronous; a clearing pass zeroes every bin of the memory, during
// which no item is accepted.
// Depends on hqe_pkg, hqe_ctrl, hqe_datapath, hqe_divider.
`timescale 1ns / 1ps
module histogram_quartile_estimator import hqe_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);
  cmd_t cmd;
  sts_t sts;

  hqe_ctrl u_ctrl (.clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_item(in_item), .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts));
  hqe_datapath u_dp (.clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .res(out_item));
endmodule
